// ----- sv/sarl_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package sarl_pkg;

  localparam int unsigned MAX_TEXT = 1023;
  localparam int unsigned IDX_W    = 10;
  localparam int unsigned DEPTH    = 1024;
  localparam int unsigned N_W      = 11;
  localparam int unsigned CNT_W    = 11;
  localparam logic [7:0]  END_MARK = 8'd36;
  localparam logic [10:0] BYTE_LIM_M1 = 11'd255;

  typedef enum logic [1:0] {
    STAT_OK      = 2'd0,
    STAT_FINAL   = 2'd1,
    STAT_RANGE   = 2'd2,
    STAT_NOBUILD = 2'd3
  } status_t;

  typedef enum logic {
    ACT_LOAD = 1'b0,
    ACT_READ = 1'b1
  } action_t;

  typedef enum logic [5:0] {
    BS_IDLE, BS_TERM, BS_CLR,
    BS_HA, BS_HB, BS_HC,
    BS_PA, BS_PB,
    BS_ZA, BS_ZB, BS_ZC,
    BS_CA, BS_CB, BS_CC,
    BS_QA, BS_QB,
    BS_RA, BS_RB, BS_RC, BS_RD,
    BS_DA, BS_DB, BS_DC, BS_DD,
    BS_KA, BS_KB,
    BS_TA, BS_TB,
    BS_LA, BS_LB, BS_LC, BS_LD, BS_LE, BS_LF, BS_LW
  } bstate_t;

  // Control from the front end to the build engine.
  typedef struct packed {
    logic              go;
    logic              ld_we;
    logic [IDX_W-1:0]  ld_addr;
    logic [7:0]        ld_sym;
    logic [N_W-1:0]    len;
    logic [IDX_W-1:0]  rank;
  } sarl_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } sarl_sts_t;

  // x is known to be below 2n.
  function automatic logic [IDX_W-1:0] wrap_idx(logic [N_W:0] x, logic [N_W-1:0] n);
    logic [N_W:0] y;
    y = (x >= {1'b0, n}) ? (x - {1'b0, n}) : x;
    return y[IDX_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ----- sv/sarl_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sarl_ram #(
  parameter int unsigned W = 10,
  parameter int unsigned D = 1024
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ----- sv/sarl_build.sv -----
`timescale 1ns / 1ps
`default_nettype none
module sarl_build (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire sarl_pkg::sarl_ctl_t ctl,
  output sarl_pkg::sarl_sts_t     sts,
  output logic [sarl_pkg::IDX_W-1:0] ord_q,
  output logic [sarl_pkg::IDX_W-1:0] lcp_q
);
  import sarl_pkg::*;

  bstate_t st_r, st_nxt;
  logic [N_W-1:0]   n_r, n_nxt, i_r, i_nxt, k_r, k_nxt, acc_r, acc_nxt;
  logic [N_W:0]     sh_r, sh_nxt;
  logic [IDX_W-1:0] key_r, key_nxt, v_r, v_nxt, c1_r, c1_nxt, pc1_r, pc1_nxt;
  logic [IDX_W-1:0] pc2_r, pc2_nxt, prv_r, prv_nxt, j_r, j_nxt, r_r, r_nxt;
  logic [7:0]       pb_r, pb_nxt, t1_r, t1_nxt;
  logic             first_r, first_nxt;

  logic             txt_we, cnt_we, ord_we, cls_we, scr_we, rop_we, lcp_we;
  logic [IDX_W-1:0] txt_wa, cnt_wa, ord_wa, cls_wa, scr_wa, rop_wa, lcp_wa;
  logic [IDX_W-1:0] txt_ra, cnt_ra, ord_ra, cls_ra, scr_ra, rop_ra;
  logic [7:0]       txt_wd, txt_rd;
  logic [CNT_W-1:0] cnt_wd, cnt_rd;
  logic [IDX_W-1:0] ord_wd, cls_wd, scr_wd, rop_wd, lcp_wd;
  logic [IDX_W-1:0] ord_rd, cls_rd, scr_rd, rop_rd;

  logic [N_W-1:0]   n_m1, lim_m1, cnt_dec;
  logic [N_W:0]     ik, jk;
  logic             i_end;
  logic [IDX_W-1:0] cc_cls, dd_cls;

  assign n_m1    = n_r - 11'd1;
  assign lim_m1  = first_r ? BYTE_LIM_M1 : n_m1;
  assign i_end   = (i_r == n_m1);
  assign cnt_dec = cnt_rd - 11'd1;
  assign ik      = {1'b0, i_r} + {1'b0, k_r};
  assign jk      = {2'b0, j_r} + {1'b0, k_r};
  assign cc_cls  = (i_r == '0) ? '0 : prv_r + IDX_W'(txt_rd != pb_r);
  assign dd_cls  = (i_r == '0) ? '0 :
                   prv_r + IDX_W'((c1_r != pc1_r) || (cls_rd != pc2_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= BS_IDLE;
    end else begin
      st_r <= st_nxt;
    end
    n_r <= n_nxt;  i_r <= i_nxt;  k_r <= k_nxt;  acc_r <= acc_nxt;
    sh_r <= sh_nxt;  key_r <= key_nxt;  v_r <= v_nxt;  c1_r <= c1_nxt;
    pc1_r <= pc1_nxt;  pc2_r <= pc2_nxt;  prv_r <= prv_nxt;  j_r <= j_nxt;
    r_r <= r_nxt;  pb_r <= pb_nxt;  t1_r <= t1_nxt;  first_r <= first_nxt;
  end

  // Next state and sequencer registers.
  always_comb begin
    st_nxt = st_r;
    n_nxt = n_r;  i_nxt = i_r;  k_nxt = k_r;  acc_nxt = acc_r;  sh_nxt = sh_r;
    key_nxt = key_r;  v_nxt = v_r;  c1_nxt = c1_r;  pc1_nxt = pc1_r;
    pc2_nxt = pc2_r;  prv_nxt = prv_r;  j_nxt = j_r;  r_nxt = r_r;
    pb_nxt = pb_r;  t1_nxt = t1_r;  first_nxt = first_r;
    unique case (st_r)
      BS_IDLE: begin
        if (ctl.go) begin
          n_nxt = ctl.len + 11'd1;
          first_nxt = 1'b1;
          st_nxt = BS_TERM;
        end
      end
      BS_TERM: begin
        i_nxt = '0;
        st_nxt = BS_CLR;
      end
      BS_CLR: begin
        if (i_r == lim_m1) begin
          i_nxt = '0;
          st_nxt = BS_HA;
        end else begin
          i_nxt = i_r + 11'd1;
        end
      end
      BS_HA: st_nxt = BS_HB;
      BS_HB: begin
        key_nxt = first_r ? {2'b0, txt_rd} : cls_rd;
        st_nxt = BS_HC;
      end
      BS_HC: begin
        if (i_end) begin
          i_nxt = '0;
          acc_nxt = '0;
          st_nxt = BS_PA;
        end else begin
          i_nxt = i_r + 11'd1;
          st_nxt = BS_HA;
        end
      end
      BS_PA: st_nxt = BS_PB;
      BS_PB: begin
        acc_nxt = acc_r + cnt_rd;
        if (i_r == lim_m1) begin
          if (first_r) begin
            i_nxt = n_m1;
            st_nxt = BS_ZA;
          end else begin
            i_nxt = '0;
            st_nxt = BS_QA;
          end
        end else begin
          i_nxt = i_r + 11'd1;
          st_nxt = BS_PA;
        end
      end
      BS_ZA: st_nxt = BS_ZB;
      BS_ZB: begin
        key_nxt = {2'b0, txt_rd};
        st_nxt = BS_ZC;
      end
      BS_ZC: begin
        if (i_r == '0) begin
          st_nxt = BS_CA;
        end else begin
          i_nxt = i_r - 11'd1;
          st_nxt = BS_ZA;
        end
      end
      BS_CA: st_nxt = BS_CB;
      BS_CB: begin
        v_nxt = ord_rd;
        st_nxt = BS_CC;
      end
      BS_CC: begin
        pb_nxt = txt_rd;
        prv_nxt = cc_cls;
        if (i_end) begin
          i_nxt = '0;
          sh_nxt = 12'd1;
          first_nxt = 1'b0;
          st_nxt = (n_r > 11'd1) ? BS_CLR : BS_TA;
        end else begin
          i_nxt = i_r + 11'd1;
          st_nxt = BS_CA;
        end
      end
      BS_QA: st_nxt = BS_QB;
      BS_QB: begin
        if (i_end) begin
          i_nxt = '0;
          st_nxt = BS_RA;
        end else begin
          i_nxt = i_r + 11'd1;
          st_nxt = BS_QA;
        end
      end
      BS_RA: st_nxt = BS_RB;
      BS_RB: begin
        v_nxt = scr_rd;
        st_nxt = BS_RC;
      end
      BS_RC: begin
        key_nxt = cls_rd;
        st_nxt = BS_RD;
      end
      BS_RD: begin
        if (i_end) begin
          i_nxt = '0;
          st_nxt = BS_DA;
        end else begin
          i_nxt = i_r + 11'd1;
          st_nxt = BS_RA;
        end
      end
      BS_DA: st_nxt = BS_DB;
      BS_DB: begin
        v_nxt = ord_rd;
        st_nxt = BS_DC;
      end
      BS_DC: begin
        c1_nxt = cls_rd;
        st_nxt = BS_DD;
      end
      BS_DD: begin
        pc1_nxt = c1_r;
        pc2_nxt = cls_rd;
        prv_nxt = dd_cls;
        if (i_end) begin
          i_nxt = '0;
          st_nxt = BS_KA;
        end else begin
          i_nxt = i_r + 11'd1;
          st_nxt = BS_DA;
        end
      end
      BS_KA: st_nxt = BS_KB;
      BS_KB: begin
        if (i_end) begin
          i_nxt = '0;
          sh_nxt = sh_r << 1;
          st_nxt = ((sh_r << 1) < {1'b0, n_r}) ? BS_CLR : BS_TA;
        end else begin
          i_nxt = i_r + 11'd1;
          st_nxt = BS_KA;
        end
      end
      BS_TA: st_nxt = BS_TB;
      BS_TB: begin
        if (i_end) begin
          i_nxt = '0;
          k_nxt = '0;
          st_nxt = BS_LA;
        end else begin
          i_nxt = i_r + 11'd1;
          st_nxt = BS_TA;
        end
      end
      BS_LA: st_nxt = BS_LB;
      BS_LB: begin
        r_nxt = rop_rd;
        if ({1'b0, rop_rd} == n_m1) begin
          k_nxt = '0;
          i_nxt = i_r + 11'd1;
          st_nxt = i_end ? BS_IDLE : BS_LA;
        end else begin
          st_nxt = BS_LC;
        end
      end
      BS_LC: begin
        j_nxt = ord_rd;
        st_nxt = BS_LD;
      end
      BS_LD: st_nxt = (ik < {1'b0, n_r} && jk < {1'b0, n_r}) ? BS_LE : BS_LW;
      BS_LE: begin
        t1_nxt = txt_rd;
        st_nxt = BS_LF;
      end
      BS_LF: begin
        if (txt_rd == t1_r) begin
          k_nxt = k_r + 11'd1;
          st_nxt = BS_LD;
        end else begin
          st_nxt = BS_LW;
        end
      end
      BS_LW: begin
        k_nxt = (k_r != '0) ? k_r - 11'd1 : '0;
        i_nxt = i_r + 11'd1;
        st_nxt = i_end ? BS_IDLE : BS_LA;
      end
      default: st_nxt = BS_IDLE;
    endcase
  end

  // Memory ports.
  always_comb begin
    txt_we = 1'b0;  txt_wa = ctl.ld_addr;  txt_wd = ctl.ld_sym;
    cnt_we = 1'b0;  cnt_wa = key_r;  cnt_wd = cnt_dec;
    ord_we = 1'b0;  ord_wa = cnt_dec[IDX_W-1:0];  ord_wd = v_r;
    cls_we = 1'b0;  cls_wa = v_r;  cls_wd = cc_cls;
    scr_we = 1'b0;  scr_wa = v_r;  scr_wd = dd_cls;
    rop_we = 1'b0;  rop_wa = ord_rd;  rop_wd = i_r[IDX_W-1:0];
    lcp_we = 1'b0;  lcp_wa = r_r;  lcp_wd = k_r[IDX_W-1:0];
    txt_ra = i_r[IDX_W-1:0];
    cnt_ra = i_r[IDX_W-1:0];
    ord_ra = i_r[IDX_W-1:0];
    cls_ra = i_r[IDX_W-1:0];
    scr_ra = i_r[IDX_W-1:0];
    rop_ra = i_r[IDX_W-1:0];
    sts.busy = (st_r != BS_IDLE);
    sts.done = 1'b0;
    unique case (st_r)
      BS_IDLE: begin
        txt_we = ctl.ld_we;
        ord_ra = ctl.rank;
      end
      BS_TERM: begin
        txt_we = 1'b1;
        txt_wa = n_m1[IDX_W-1:0];
        txt_wd = END_MARK;
      end
      BS_CLR: begin
        cnt_we = 1'b1;
        cnt_wa = i_r[IDX_W-1:0];
        cnt_wd = '0;
      end
      BS_HB: cnt_ra = first_r ? {2'b0, txt_rd} : cls_rd;
      BS_HC: begin
        cnt_we = 1'b1;
        cnt_wd = cnt_rd + 11'd1;
      end
      BS_PB: begin
        cnt_we = 1'b1;
        cnt_wa = i_r[IDX_W-1:0];
        cnt_wd = acc_r + cnt_rd;
      end
      BS_ZB: cnt_ra = {2'b0, txt_rd};
      BS_ZC: begin
        cnt_we = 1'b1;
        ord_we = 1'b1;
        ord_wd = i_r[IDX_W-1:0];
      end
      BS_CB: txt_ra = ord_rd;
      BS_CC: cls_we = 1'b1;
      BS_QB: begin
        scr_we = 1'b1;
        scr_wa = n_m1[IDX_W-1:0] - i_r[IDX_W-1:0];
        scr_wd = wrap_idx({2'b0, ord_rd} + {1'b0, n_r} - sh_r, n_r);
      end
      BS_RB: cls_ra = scr_rd;
      BS_RC: cnt_ra = cls_rd;
      BS_RD: begin
        cnt_we = 1'b1;
        ord_we = 1'b1;
      end
      BS_DB: cls_ra = ord_rd;
      BS_DC: cls_ra = wrap_idx({2'b0, v_r} + sh_r, n_r);
      BS_DD: scr_we = 1'b1;
      BS_KB: begin
        cls_we = 1'b1;
        cls_wa = i_r[IDX_W-1:0];
        cls_wd = scr_rd;
      end
      BS_TB: rop_we = 1'b1;
      BS_LB: begin
        ord_ra = rop_rd + 10'd1;
        sts.done = ({1'b0, rop_rd} == n_m1) && i_end;
      end
      BS_LD: txt_ra = ik[IDX_W-1:0];
      BS_LE: txt_ra = jk[IDX_W-1:0];
      BS_LW: begin
        lcp_we = 1'b1;
        sts.done = i_end;
      end
      default: ;
    endcase
  end

  sarl_ram #(.W(8), .D(DEPTH)) u_txt (.clk(clk), .we(txt_we), .waddr(txt_wa),
    .wdata(txt_wd), .raddr(txt_ra), .rdata(txt_rd));
  sarl_ram #(.W(CNT_W), .D(DEPTH)) u_cnt (.clk(clk), .we(cnt_we), .waddr(cnt_wa),
    .wdata(cnt_wd), .raddr(cnt_ra), .rdata(cnt_rd));
  sarl_ram #(.W(IDX_W), .D(DEPTH)) u_ord (.clk(clk), .we(ord_we), .waddr(ord_wa),
    .wdata(ord_wd), .raddr(ord_ra), .rdata(ord_rd));
  sarl_ram #(.W(IDX_W), .D(DEPTH)) u_cls (.clk(clk), .we(cls_we), .waddr(cls_wa),
    .wdata(cls_wd), .raddr(cls_ra), .rdata(cls_rd));
  sarl_ram #(.W(IDX_W), .D(DEPTH)) u_scr (.clk(clk), .we(scr_we), .waddr(scr_wa),
    .wdata(scr_wd), .raddr(scr_ra), .rdata(scr_rd));
  sarl_ram #(.W(IDX_W), .D(DEPTH)) u_rop (.clk(clk), .we(rop_we), .waddr(rop_wa),
    .wdata(rop_wd), .raddr(rop_ra), .rdata(rop_rd));
  sarl_ram #(.W(IDX_W), .D(DEPTH)) u_lcp (.clk(clk), .we(lcp_we), .waddr(lcp_wa),
    .wdata(lcp_wd), .raddr(ctl.rank), .rdata(lcp_q));

  assign ord_q = ord_rd;

  // A bucket is never taken below zero while placing.
  a_zc_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BS_ZC) |-> (cnt_rd != '0)) else $error("bucket underflow in byte sort");
  a_rd_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BS_RD) |-> (cnt_rd != '0)) else $error("bucket underflow in pair sort");
  a_lcp_k: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BS_LD) |-> (k_r <= n_r)) else $error("prefix length beyond text");
  a_go: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == BS_IDLE && ctl.go) |=> (st_r == BS_TERM)) else $error("build did not start");
endmodule
`default_nettype wire

// ----- sv/suffix_array_with_lcp_builder_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none
// Load word: busy stays low unless it carries last.
// Build after a last word (n = length + 1): busy stays high through the byte sort, each
// doubling round, the rank inversion, then the prefix-length pass over every position.
// Read word: the result strobe is registered through rds_r, then vld_r; busy is high while rds_r is set.
// The result cannot be stalled by the receiver.
// Synchronous active-low reset clears the length, built and overflow flags; memories keep data.
module suffix_array_with_lcp_builder_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        in_action,
  input  wire logic [7:0]  in_symbol,
  input  wire logic        in_last,
  input  wire logic [9:0]  in_rank,
  output logic             out_valid,
  output logic [9:0]       out_position,
  output logic [9:0]       out_common_prefix,
  output logic [1:0]       out_status,
  output logic             out_overflowed
);
  import sarl_pkg::*;

  logic [N_W-1:0]   len_r, len_nxt, eff_len, n_cur;
  logic             built_r, built_nxt, ovf_r, ovf_nxt, go_r, go_nxt;
  logic             rds_r, vld_r;
  logic [IDX_W-1:0] rank_r, pos_r, lcp_r;
  status_t          stat_r, stat_nxt;
  logic             acc, ld, room;
  sarl_ctl_t        ctl;
  sarl_sts_t        sts;
  logic [IDX_W-1:0] ord_q, lcp_q;

  assign busy    = go_r | sts.busy | rds_r;
  assign acc     = start & ~busy;
  assign ld      = acc & (in_action == ACT_LOAD);
  assign eff_len = built_r ? '0 : len_r;
  assign room    = (eff_len < N_W'(MAX_TEXT));
  assign n_cur   = len_r + 11'd1;

  always_comb begin
    len_nxt = len_r;
    built_nxt = built_r;
    ovf_nxt = ovf_r;
    go_nxt = ld & in_last;
    if (ld) begin
      built_nxt = 1'b0;
      ovf_nxt = (built_r ? 1'b0 : ovf_r) | ~room;
      if (room) begin
        len_nxt = eff_len + 11'd1;
      end
    end else if (sts.done) begin
      built_nxt = 1'b1;
    end
  end

  always_comb begin
    ctl.go = go_r;
    ctl.ld_we = ld & room;
    ctl.ld_addr = eff_len[IDX_W-1:0];
    ctl.ld_sym = in_symbol;
    ctl.len = len_r;
    ctl.rank = rds_r ? rank_r : in_rank;
  end

  always_comb begin
    if (!built_r) begin
      stat_nxt = STAT_NOBUILD;
    end else if ({1'b0, rank_r} >= n_cur) begin
      stat_nxt = STAT_RANGE;
    end else if ({1'b0, rank_r} == len_r) begin
      stat_nxt = STAT_FINAL;
    end else begin
      stat_nxt = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
      built_r <= 1'b0;
      ovf_r <= 1'b0;
      go_r <= 1'b0;
      rds_r <= 1'b0;
      vld_r <= 1'b0;
    end else begin
      len_r <= len_nxt;
      built_r <= built_nxt;
      ovf_r <= ovf_nxt;
      go_r <= go_nxt;
      rds_r <= acc & (in_action == ACT_READ);
      vld_r <= rds_r;
    end
    if (acc) begin
      rank_r <= in_rank;
    end
    if (rds_r) begin
      stat_r <= stat_nxt;
      pos_r <= (stat_nxt == STAT_OK || stat_nxt == STAT_FINAL) ? ord_q : '0;
      lcp_r <= (stat_nxt == STAT_OK) ? lcp_q : '0;
    end
  end

  sarl_build u_build (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .sts   (sts),
    .ord_q (ord_q),
    .lcp_q (lcp_q)
  );

  assign out_valid         = vld_r;
  assign out_position      = pos_r;
  assign out_common_prefix = lcp_r;
  assign out_status        = stat_r;
  assign out_overflowed    = ovf_r;

  a_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(rds_r)) else $error("result word without a read");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    go_r |-> busy) else $error("idle while a build is pending");
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= N_W'(MAX_TEXT)) else $error("text length beyond capacity");
endmodule
`default_nettype wire

// ----- tb/tb.sv -----
`timescale 1ns / 1ps
module tb;
  import sarl_pkg::*;

  localparam int unsigned ITEMS = 1550;
  localparam int unsigned WD_LIMIT = 1500000;

  typedef struct {
    logic [9:0] pos;
    logic [9:0] lcp;
    status_t    st;
    logic       ovf;
  } sa_result_t;

  typedef struct {
    action_t    act;
    logic [7:0] sym;
    logic       lst;
    logic [9:0] rk;
    bit         typed;
    sa_result_t res;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic in_action = 1'b0;
  logic [7:0] in_symbol = 8'd0;
  logic in_last = 1'b0;
  logic [9:0] in_rank = 10'd0;
  logic busy, out_valid, out_overflowed;
  logic [9:0] out_position, out_common_prefix;
  logic [1:0] out_status;

  suffix_array_with_lcp_builder_unit i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_action(in_action), .in_symbol(in_symbol), .in_last(in_last), .in_rank(in_rank),
    .out_valid(out_valid), .out_position(out_position),
    .out_common_prefix(out_common_prefix), .out_status(out_status),
    .out_overflowed(out_overflowed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Shadow copy of the suffix sorter.
  int txt [DEPTH];
  int sa_order [DEPTH];
  int eq_class [DEPTH];
  int work [DEPTH];
  int bucket [DEPTH];
  int inv_order [DEPTH];
  int lcp_tab [DEPTH];
  int text_len = 0;
  bit is_built = 0;
  bit is_over = 0;

  sa_result_t pending_results[$];
  int fails = 0;
  int words_sent = 0;
  int idle_pct = 0;
  int quiet_cycles = 0;

  task automatic sort_suffixes();
    int n, sh, v, a, b, r, j, k;
    bit diff;
    n = text_len + 1;
    txt[text_len] = END_MARK;
    for (int i = 0; i < DEPTH; i++) bucket[i] = 0;
    for (int i = 0; i < n; i++) bucket[txt[i]]++;
    for (int i = 1; i < 256; i++) bucket[i] += bucket[i-1];
    for (int i = n - 1; i >= 0; i--) begin
      bucket[txt[i]]--;
      sa_order[bucket[txt[i]]] = i;
    end
    eq_class[sa_order[0]] = 0;
    for (int i = 1; i < n; i++)
      eq_class[sa_order[i]] = eq_class[sa_order[i-1]] +
          ((txt[sa_order[i]] != txt[sa_order[i-1]]) ? 1 : 0);
    for (sh = 1; sh < n; sh = sh * 2) begin
      for (int i = 0; i < DEPTH; i++) bucket[i] = 0;
      for (int i = 0; i < n; i++) bucket[eq_class[i]]++;
      for (int i = 1; i < n; i++) bucket[i] += bucket[i-1];
      for (int i = 0; i < n; i++) work[n-1-i] = (sa_order[i] + n - sh) % n;
      for (int i = 0; i < n; i++) begin
        v = work[i];
        bucket[eq_class[v]]--;
        sa_order[bucket[eq_class[v]]] = v;
      end
      work[sa_order[0]] = 0;
      for (int i = 1; i < n; i++) begin
        a = sa_order[i];
        b = sa_order[i-1];
        diff = (eq_class[a] != eq_class[b]) ||
               (eq_class[(a + sh) % n] != eq_class[(b + sh) % n]);
        work[a] = work[b] + (diff ? 1 : 0);
      end
      for (int i = 0; i < n; i++) eq_class[i] = work[i];
    end
    for (int i = 0; i < n; i++) inv_order[sa_order[i]] = i;
    k = 0;
    for (int i = 0; i < n; i++) begin
      r = inv_order[i];
      if (r == n - 1) begin
        k = 0;
      end else begin
        j = sa_order[r+1];
        while (i + k < n && j + k < n && txt[i+k] == txt[j+k]) k++;
        lcp_tab[r] = k;
        if (k > 0) k--;
      end
    end
    is_built = 1;
  endtask

  task automatic append_byte(logic [7:0] sym, logic lst);
    if (is_built) begin
      text_len = 0;
      is_built = 0;
      is_over = 0;
    end
    if (text_len < MAX_TEXT) begin
      txt[text_len] = sym;
      text_len++;
    end else begin
      is_over = 1;
    end
    if (lst) sort_suffixes();
  endtask

  function automatic sa_result_t lookup_rank(logic [9:0] rk);
    sa_result_t r;
    int n;
    n = text_len + 1;
    r.pos = '0;
    r.lcp = '0;
    r.ovf = is_over;
    if (!is_built) begin
      r.st = STAT_NOBUILD;
    end else if (rk >= n) begin
      r.st = STAT_RANGE;
    end else if (rk == n - 1) begin
      r.st = STAT_FINAL;
      r.pos = sa_order[rk];
    end else begin
      r.st = STAT_OK;
      r.pos = sa_order[rk];
      r.lcp = lcp_tab[rk];
    end
    return r;
  endfunction

  // Called in a rising-edge step; returns in the step of the accepting edge.
  task automatic send_word(action_t act, logic [7:0] sym, logic lst, logic [9:0] rk,
                           bit typed, sa_result_t tab);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_action <= act;
    in_symbol <= sym;
    in_last <= lst;
    in_rank <= rk;
    @(negedge clk);
    while (busy) @(negedge clk);
    @(posedge clk);
    if (act == ACT_LOAD) begin
      append_byte(sym, lst);
    end else begin
      pending_results.push_back(typed ? tab : lookup_rank(rk));
    end
    words_sent++;
  endtask

  function automatic logic [7:0] pick_symbol(int alpha);
    case (alpha)
      0: pick_symbol = $urandom_range(0, 255);
      1: pick_symbol = 8'h61 + $urandom_range(0, 2);
      default: pick_symbol = $urandom_range(0, 1) ? END_MARK : 8'h61;
    endcase
  endfunction

  always @(negedge clk) begin
    sa_result_t e;
    if (out_valid) begin
      if (pending_results.size() == 0) begin
        $error("unexpected result word: position %0d", out_position);
        fails++;
      end else begin
        e = pending_results.pop_front();
        if (out_position !== e.pos) begin
          $error("position: expected %0d, got %0d", e.pos, out_position);
          fails++;
        end
        if (out_common_prefix !== e.lcp) begin
          $error("common_prefix: expected %0d, got %0d", e.lcp, out_common_prefix);
          fails++;
        end
        if (out_status !== e.st) begin
          $error("status: expected %0d, got %0d", e.st, out_status);
          fails++;
        end
        if (out_overflowed !== e.ovf) begin
          $error("overflowed: expected %0d, got %0d", e.ovf, out_overflowed);
          fails++;
        end
      end
    end
  end

  // Build passes keep busy high for a long time, so the limit is generous.
  always @(negedge clk) begin
    if (rst_n && ((start && !busy) || out_valid)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WD_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    stim_row_t rows[$];
    sa_result_t none, nob, rng;
    int phase, n, len, alpha, reads;
    int pct[4];
    bit big_done;
    pct = '{0, 51, 0, 24};
    none = '{pos: '0, lcp: '0, st: STAT_OK, ovf: 1'b0};
    nob = '{pos: '0, lcp: '0, st: STAT_NOBUILD, ovf: 1'b0};
    rng = '{pos: '0, lcp: '0, st: STAT_RANGE, ovf: 1'b0};
    rows.push_back('{ACT_READ, 8'h00, 1'b0, 10'd0, 1, nob});
    rows.push_back('{ACT_READ, 8'hFF, 1'b1, 10'd1023, 1, nob});
    rows.push_back('{ACT_LOAD, 8'h00, 1'b0, 10'd0, 0, none});
    rows.push_back('{ACT_LOAD, 8'hFF, 1'b0, 10'd1023, 0, none});
    rows.push_back('{ACT_LOAD, END_MARK, 1'b0, 10'd0, 0, none});
    rows.push_back('{ACT_LOAD, 8'h55, 1'b1, 10'd0, 0, none});
    for (int r = 0; r < 5; r++) rows.push_back('{ACT_READ, 8'h00, 1'b0, r, 0, none});
    rows.push_back('{ACT_READ, 8'h00, 1'b0, 10'd5, 1, rng});
    rows.push_back('{ACT_READ, 8'hFF, 1'b1, 10'd1023, 1, rng});
    // A load after a build throws the old string away.
    rows.push_back('{ACT_LOAD, 8'hAA, 1'b0, 10'd0, 0, none});
    rows.push_back('{ACT_READ, 8'h00, 1'b0, 10'd0, 1, nob});
    rows.push_back('{ACT_LOAD, 8'h61, 1'b1, 10'd0, 0, none});
    for (int r = 0; r < 3; r++) rows.push_back('{ACT_READ, 8'h00, 1'b1, r, 0, none});
    rows.push_back('{ACT_READ, 8'h00, 1'b0, 10'd3, 1, rng});

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (rows[i])
      send_word(rows[i].act, rows[i].sym, rows[i].lst, rows[i].rk, rows[i].typed, rows[i].res);

    phase = -1;
    big_done = 0;
    while (words_sent < ITEMS) begin
      if (phase != (words_sent * 4) / ITEMS && (words_sent * 4) / ITEMS < 4) begin
        phase = (words_sent * 4) / ITEMS;
        idle_pct = pct[phase];
        start <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 9) == 0) begin
        send_word($urandom_range(0, 1) ? ACT_READ : ACT_LOAD, $urandom_range(0, 255),
                  1'b0, $urandom_range(0, 1023), 0, none);
      end else begin
        alpha = $urandom_range(0, 2);
        if (!big_done && words_sent > 300) begin
          // Full string past capacity; the last mark lands on a dropped byte.
          big_done = 1;
          for (int i = 0; i < MAX_TEXT + 2; i++)
            send_word(ACT_LOAD, ($urandom_range(0, 49) == 0) ? $urandom_range(0, 255) : 8'h61,
                      i == MAX_TEXT + 1, $urandom_range(0, 1023), 0, none);
        end else begin
          len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
          for (int i = 0; i < len; i++)
            send_word(ACT_LOAD, pick_symbol(alpha), i == len - 1, $urandom_range(0, 1023),
                      0, none);
        end
        n = text_len + 1;
        reads = big_done && n == DEPTH ? 20 : $urandom_range(3, 10);
        for (int i = 0; i < reads; i++)
          send_word(ACT_READ, $urandom_range(0, 255), $urandom_range(0, 1),
                    ($urandom_range(0, 4) == 0) ? $urandom_range(0, 1023)
                                                : $urandom_range(0, n + 1), 0, none);
      end
    end
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
